/* rtl/core/ring_copy_pointer_manager_unit_macros.svh */
// Assertion macros for the ring copy pointer manager.
// Used by the top level only; needs no package.
`ifndef RING_COPY_POINTER_MANAGER_UNIT_MACROS_SVH
`define RING_COPY_POINTER_MANAGER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RCPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RCPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rcpm_pkg.sv */
// Shared types and constants for the ring copy pointer manager.
// No dependencies.
`default_nettype none

package rcpm_pkg;

  // Device ring size in dwords; the dword counters are CNT_W bits wide.
  localparam int RING_DWORDS = 1024;
  localparam int SRC_BYTES_DEF = 4096;
  localparam int DST_BYTES_DEF = 8192;

  // Field widths.
  localparam int ACT_W = 2;
  localparam int CNT_W = 10;
  localparam int REQ_W = 14;
  localparam int ST_W = 2;
  localparam int OFF_W = 13;
  localparam int LEN_W = 14;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_FILL  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DRAIN = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESET = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE     = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] read_count;
    logic [REQ_W-1:0] request_length;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] from_offset;
    logic [OFF_W-1:0] to_offset;
    logic [LEN_W-1:0] length;
    logic [CNT_W-1:0] new_read_count;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/rcpm_if.sv */
// Valid/ready channel interfaces for the request and result sides.
// Depends on rcpm_pkg for field widths.
`default_nettype none

interface rcpm_in_if;
  logic                         valid;
  logic                         ready;
  logic [rcpm_pkg::ACT_W-1:0]   action;
  logic [rcpm_pkg::CNT_W-1:0]   write_count;
  logic [rcpm_pkg::CNT_W-1:0]   read_count;
  logic [rcpm_pkg::REQ_W-1:0]   request_length;

  modport source (output valid, action, write_count, read_count, request_length,
                  input ready);
  modport sink (input valid, action, write_count, read_count, request_length,
                output ready);
endinterface

interface rcpm_out_if;
  logic                         valid;
  logic                         ready;
  logic [rcpm_pkg::ST_W-1:0]    status;
  logic [rcpm_pkg::OFF_W-1:0]   from_offset;
  logic [rcpm_pkg::OFF_W-1:0]   to_offset;
  logic [rcpm_pkg::LEN_W-1:0]   length;
  logic [rcpm_pkg::CNT_W-1:0]   new_read_count;

  modport source (output valid, status, from_offset, to_offset, length, new_read_count,
                  input ready);
  modport sink (input valid, status, from_offset, to_offset, length, new_read_count,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/rcpm_calc.sv */
// Combinational pointer arithmetic for one fill, drain or reset request.
// Depends on rcpm_pkg.
`default_nettype none

module rcpm_calc #(
  parameter int SRC_BYTES = rcpm_pkg::SRC_BYTES_DEF,
  parameter int DST_BYTES = rcpm_pkg::DST_BYTES_DEF,
  parameter int SRC_W = $clog2(SRC_BYTES),
  parameter int DST_W = $clog2(DST_BYTES)
) (
  input  rcpm_pkg::req_t   req,
  input  logic [SRC_W-1:0] src_tail,
  input  logic [DST_W-1:0] dst_head,
  input  logic [DST_W-1:0] dst_tail,
  output rcpm_pkg::res_t   res,
  output logic [SRC_W-1:0] src_tail_nxt,
  output logic [DST_W-1:0] dst_head_nxt,
  output logic [DST_W-1:0] dst_tail_nxt
);
  import rcpm_pkg::*;

  // Working width: covers ring sizes plus one, 4 * RING_DWORDS and the request.
  localparam int LEN4_W = $clog2(4 * RING_DWORDS + 1);
  localparam int MA_W = (SRC_W > DST_W) ? SRC_W : DST_W;
  localparam int MB_W = (LEN4_W > REQ_W) ? LEN4_W : REQ_W;
  localparam int CW = ((MA_W + 1 > MB_W) ? MA_W + 1 : MB_W) + 1;

  logic          empty;
  logic [CW-1:0] rc_w, wc_w, st_w, req_w;
  logic [CW-1:0] dh_e, dt_e, dh_w, dt_w;
  logic [CW-1:0] slen0, slen1, slen2;
  logic [CW-1:0] room, free_b, blen;
  logic [CW-1:0] st_sum, dh_sum, dt_sum, nrc_sum;

  // Size the fill and drain chunks
  always_comb begin
    rc_w  = CW'(req.read_count);
    wc_w  = CW'(req.write_count);
    req_w = CW'(req.request_length);
    st_w  = CW'(src_tail);
    dh_w  = CW'(dst_head);
    dt_w  = CW'(dst_tail);
    empty = (dst_head == dst_tail);
    // An empty destination ring restarts at offset zero
    dh_e  = empty ? '0 : dh_w;
    dt_e  = empty ? '0 : dt_w;

    // Source length from the device counters, wrapping writer handled to ring end
    if (rc_w > wc_w) begin
      slen0 = (rc_w >= CW'(RING_DWORDS)) ? '0 : ((CW'(RING_DWORDS) - rc_w) << 2);
    end else begin
      slen0 = (wc_w - rc_w) << 2;
    end
    slen1 = (st_w + slen0 > CW'(SRC_BYTES)) ? (CW'(SRC_BYTES) - st_w) : slen0;

    // Contiguous room and total free space, one byte kept free
    if (dt_e <= dh_e) begin
      room   = CW'(DST_BYTES) - dh_e;
      free_b = room + dt_e - CW'(1);
    end else begin
      room   = dt_e - dh_e;
      free_b = room - CW'(1);
    end
    slen2   = (slen1 > room) ? room : slen1;
    st_sum  = st_w + slen2;
    dh_sum  = dh_e + slen2;
    nrc_sum = rc_w + (slen2 >> 2);

    // Drain chunk: up to the head or the ring end, clipped by the request
    blen = (dt_w < dh_w) ? (dh_w - dt_w) : (CW'(DST_BYTES) - dt_w);
    if (req_w < blen) begin
      blen = req_w;
    end
    dt_sum = dt_w + blen;
  end

  // Select the result and the next pointers
  always_comb begin
    res          = '0;
    src_tail_nxt = src_tail;
    dst_head_nxt = dst_head;
    dst_tail_nxt = dst_tail;
    unique case (req.action)
      ACT_FILL: begin
        dst_head_nxt = DST_W'(dh_e);
        dst_tail_nxt = DST_W'(dt_e);
        if (slen1 == '0) begin
          res.status         = ST_NONE;
          res.new_read_count = req.read_count;
        end else if (slen1 > free_b) begin
          res.status         = ST_OVERFLOW;
          res.new_read_count = req.read_count;
        end else begin
          res.status      = ST_OK;
          res.from_offset = OFF_W'(src_tail);
          res.to_offset   = OFF_W'(dh_e);
          res.length      = LEN_W'(slen2);
          // RING_DWORDS spans the full counter, so the wrap is a truncation
          res.new_read_count = nrc_sum[CNT_W-1:0];
          src_tail_nxt = (st_sum == CW'(SRC_BYTES)) ? '0 : SRC_W'(st_sum);
          dst_head_nxt = (dh_sum == CW'(DST_BYTES)) ? '0 : DST_W'(dh_sum);
        end
      end
      ACT_DRAIN: begin
        if (empty) begin
          res.status = ST_NONE;
        end else begin
          res.status      = ST_OK;
          res.from_offset = OFF_W'(dst_tail);
          res.length      = LEN_W'(blen);
          dst_tail_nxt = (dt_sum == CW'(DST_BYTES)) ? '0 : DST_W'(dt_sum);
        end
      end
      ACT_RESET: begin
        res.status   = ST_OK;
        src_tail_nxt = '0;
        dst_head_nxt = '0;
        dst_tail_nxt = '0;
      end
      default: begin
        res.status = ST_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/ring_copy_pointer_manager_unit.sv */
// Top level of the ring copy pointer manager: request and result registers,
// pointer state. Depends on rcpm_pkg, rcpm_if, rcpm_calc and the macros header.
`default_nettype none
`include "ring_copy_pointer_manager_unit_macros.svh"

// Tracks the source tail, destination head and destination tail of a two-stage
// ring copy. Each request (fill, drain or reset) yields exactly one result.
// A request is registered when accepted and evaluated against the pointers while
// it is held; its result is registered in the same edge that updates the pointers,
// and one request is taken every cycle while results are taken. A held result
// stalls the input through a combinational path from out_res.ready to in_req.ready.
// The pointer update is a loop from the pointer registers through rcpm_calc and
// back, which sets the clock rate. No clearing is needed after reset.
module ring_copy_pointer_manager_unit #(
  parameter int SRC_BYTES = rcpm_pkg::SRC_BYTES_DEF,
  parameter int DST_BYTES = rcpm_pkg::DST_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rcpm_in_if.sink    in_req,
  rcpm_out_if.source out_res
);
  import rcpm_pkg::*;

  localparam int SRC_W = $clog2(SRC_BYTES);
  localparam int DST_W = $clog2(DST_BYTES);

  logic             in_v_r, in_v_nxt;
  req_t             in_req_r;
  logic             out_v_r, out_v_nxt;
  res_t             out_res_r;
  logic [SRC_W-1:0] src_tail_r, src_tail_nxt;
  logic [DST_W-1:0] dst_head_r, dst_head_nxt;
  logic [DST_W-1:0] dst_tail_r, dst_tail_nxt;
  res_t             calc_res;
  logic             move;
  logic             in_ready;

  // Advance the held request when the result register is free or draining
  assign move     = in_v_r && (!out_v_r || out_res.ready);
  assign in_ready = !in_v_r || move;

  always_comb begin
    in_v_nxt  = in_v_r;
    out_v_nxt = out_v_r;
    if (out_v_r && out_res.ready) begin
      out_v_nxt = 1'b0;
    end
    if (move) begin
      out_v_nxt = 1'b1;
      in_v_nxt  = 1'b0;
    end
    if (in_req.valid && in_ready) begin
      in_v_nxt = 1'b1;
    end
  end

  // Evaluate the held request against the current pointers
  rcpm_calc #(
    .SRC_BYTES (SRC_BYTES),
    .DST_BYTES (DST_BYTES),
    .SRC_W     (SRC_W),
    .DST_W     (DST_W)
  ) u_calc (
    .req          (in_req_r),
    .src_tail     (src_tail_r),
    .dst_head     (dst_head_r),
    .dst_tail     (dst_tail_r),
    .res          (calc_res),
    .src_tail_nxt (src_tail_nxt),
    .dst_head_nxt (dst_head_nxt),
    .dst_tail_nxt (dst_tail_nxt)
  );

  // Control and pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      src_tail_r <= '0;
      dst_head_r <= '0;
      dst_tail_r <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (move) begin
        src_tail_r <= src_tail_nxt;
        dst_head_r <= dst_head_nxt;
        dst_tail_r <= dst_tail_nxt;
      end
    end
  end

  // Capture request and result payloads
  always_ff @(posedge clk) begin
    if (in_req.valid && in_ready) begin
      in_req_r.action         <= in_req.action;
      in_req_r.write_count    <= in_req.write_count;
      in_req_r.read_count     <= in_req.read_count;
      in_req_r.request_length <= in_req.request_length;
    end
    if (move) begin
      out_res_r <= calc_res;
    end
  end

  // Drive the channels
  assign in_req.ready           = in_ready;
  assign out_res.valid          = out_v_r;
  assign out_res.status         = out_res_r.status;
  assign out_res.from_offset    = out_res_r.from_offset;
  assign out_res.to_offset      = out_res_r.to_offset;
  assign out_res.length         = out_res_r.length;
  assign out_res.new_read_count = out_res_r.new_read_count;

  // Pointers stay inside their rings
  `RCPM_ASSERT_NOW(a_ptr_range, clk, rst_n, 1'b1, (32'(src_tail_r) < SRC_BYTES) && (32'(dst_head_r) < DST_BYTES) && (32'(dst_tail_r) < DST_BYTES), "pointer out of ring")
  // A result that is not ok carries no length
  `RCPM_ASSERT_NOW(a_len_zero, clk, rst_n, out_v_r && (out_res_r.status != ST_OK), out_res_r.length == '0, "nonzero length on failed request")
  // A reset request clears every pointer
  `RCPM_ASSERT_NEXT(a_reset_clr, clk, rst_n, move && (in_req_r.action == ACT_RESET), (src_tail_r == '0) && (dst_head_r == '0) && (dst_tail_r == '0), "reset request left a pointer set")
  // An overflowing fill leaves the source pointer alone
  `RCPM_ASSERT_NEXT(a_ovf_hold, clk, rst_n, move && (calc_res.status == ST_OVERFLOW), $stable(src_tail_r), "source tail moved on overflow")

endmodule

`default_nettype wire

/* bench/rcpm_ring_checker.sv */
`timescale 1ns / 100ps
// Checker for the ring copy pointer manager: mirrors the source tail and the
// destination head and tail, predicts every result and compares in order.
// Depends on rcpm_pkg and the channel interfaces of rcpm_if.
module rcpm_ring_checker (
  input  logic clk,
  input  logic rst_n,
  rcpm_in_if   req_mon,
  rcpm_out_if  res_mon,
  output int   fail_count,
  output int   pending
);
  import rcpm_pkg::*;

  localparam int SRC_BYTES = SRC_BYTES_DEF;
  localparam int DST_BYTES = DST_BYTES_DEF;
  localparam int REPORT_MAX = 10;

  // Mirrored pointer state
  logic [11:0]      src_tail;
  logic [OFF_W-1:0] dst_head;
  logic [OFF_W-1:0] dst_tail;

  res_t expected_results[$];
  int   fault_total = 0;

  // Work out the result of one request and advance the mirrored pointers.
  function automatic res_t ring_result(req_t r);
    res_t res;
    int wc, rc, chunk, room, free_bytes, head, tail;
    res = '0;
    wc = int'(r.write_count);
    rc = int'(r.read_count);
    case (r.action)
      ACT_FILL: begin
        // Size the chunk from the device counters, clip at the source end
        if (rc > wc) chunk = (rc >= RING_DWORDS) ? 0 : 4 * (RING_DWORDS - rc);
        else chunk = 4 * (wc - rc);
        if (int'(src_tail) + chunk > SRC_BYTES) chunk = SRC_BYTES - int'(src_tail);
        // Rewind an empty destination ring before anything else
        if (dst_head == dst_tail) begin
          dst_head = '0;
          dst_tail = '0;
        end
        head = int'(dst_head);
        tail = int'(dst_tail);
        res.new_read_count = r.read_count;
        if (chunk == 0) begin
          res.status = ST_NONE;
        end else begin
          // One byte always stays free
          if (tail <= head) begin
            room = DST_BYTES - head;
            free_bytes = room + tail - 1;
          end else begin
            room = tail - head;
            free_bytes = room - 1;
          end
          if (chunk > free_bytes) begin
            res.status = ST_OVERFLOW;
          end else begin
            if (chunk > room) chunk = room;
            res.status = ST_OK;
            res.from_offset = OFF_W'(src_tail);
            res.to_offset = OFF_W'(head);
            res.length = LEN_W'(chunk);
            res.new_read_count = CNT_W'((rc + chunk / 4) % RING_DWORDS);
            src_tail = 12'((int'(src_tail) + chunk) % SRC_BYTES);
            dst_head = OFF_W'((head + chunk) % DST_BYTES);
          end
        end
      end
      ACT_DRAIN: begin
        head = int'(dst_head);
        tail = int'(dst_tail);
        if (head == tail) begin
          res.status = ST_NONE;
        end else begin
          chunk = (tail < head) ? head - tail : DST_BYTES - tail;
          if (int'(r.request_length) < chunk) chunk = int'(r.request_length);
          res.status = ST_OK;
          res.from_offset = OFF_W'(tail);
          res.length = LEN_W'(chunk);
          dst_tail = OFF_W'((tail + chunk) % DST_BYTES);
        end
      end
      ACT_RESET: begin
        src_tail = '0;
        dst_head = '0;
        dst_tail = '0;
        res.status = ST_OK;
      end
      default: begin
        res.status = ST_NONE;
      end
    endcase
    return res;
  endfunction

  // Predict on every accepted request, compare on every accepted result
  always @(posedge clk) begin : watch
    req_t rq;
    res_t got;
    res_t want;
    if (!rst_n) begin
      src_tail = '0;
      dst_head = '0;
      dst_tail = '0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        rq.action = req_mon.action;
        rq.write_count = req_mon.write_count;
        rq.read_count = req_mon.read_count;
        rq.request_length = req_mon.request_length;
        expected_results.push_back(ring_result(rq));
      end
      if (res_mon.valid && res_mon.ready) begin
        got.status = res_mon.status;
        got.from_offset = res_mon.from_offset;
        got.to_offset = res_mon.to_offset;
        got.length = res_mon.length;
        got.new_read_count = res_mon.new_read_count;
        if (expected_results.size() == 0) begin
          fault_total++;
          if (fault_total <= REPORT_MAX)
            $display("%0t: result with none expected: st=%0d from=%0d to=%0d len=%0d nrc=%0d",
                     $realtime, got.status, got.from_offset, got.to_offset, got.length,
                     got.new_read_count);
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status || got.from_offset != want.from_offset ||
              got.to_offset != want.to_offset || got.length != want.length ||
              got.new_read_count != want.new_read_count) begin
            fault_total++;
            if (fault_total <= REPORT_MAX) begin
              $display("%0t: mismatch, expected st=%0d from=%0d to=%0d len=%0d nrc=%0d",
                       $realtime, want.status, want.from_offset, want.to_offset,
                       want.length, want.new_read_count);
              $display("%0t:           actual   st=%0d from=%0d to=%0d len=%0d nrc=%0d",
                       $realtime, got.status, got.from_offset, got.to_offset,
                       got.length, got.new_read_count);
            end
          end
        end
      end
      pending <= expected_results.size();
    end
    fail_count <= fault_total;
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Top of the ring copy pointer manager bench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on rcpm_pkg, rcpm_if and the checker.
module tb_top;
  import rcpm_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   burst_left = 0;
  int   rx_count = 0;
  int   rx_mode = 0;
  int   bias = 0;

  rcpm_in_if  req_ch ();
  rcpm_out_if res_ch ();

  ring_copy_pointer_manager_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  rcpm_ring_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_ch),
    .res_mon    (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stall the result side, switching among four randomly chosen patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (rx_count % 80 == 0) rx_mode = $urandom_range(0, 3);
      rx_count++;
      case (rx_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= ((rx_count % 16) < 5);
      endcase
    end
  end

  function automatic req_t make_request(logic [ACT_W-1:0] act, int wc, int rc, int len);
    req_t r;
    r.action = act;
    r.write_count = CNT_W'(wc);
    r.read_count = CNT_W'(rc);
    r.request_length = REQ_W'(len);
    return r;
  endfunction

  // Draw a request; bias 0 balanced, 1 fill heavy, 2 drain heavy
  function automatic req_t random_request(int mode);
    req_t r;
    int pick, fill_pct;
    r.write_count = CNT_W'($urandom);
    r.read_count = CNT_W'($urandom);
    r.request_length = REQ_W'($urandom);
    fill_pct = (mode == 1) ? 75 : (mode == 2) ? 25 : 48;
    pick = $urandom_range(0, 99);
    if (pick < fill_pct) begin
      r.action = ACT_FILL;
      // Mostly a device writer a little ahead of its reader, wrapping at times
      if ($urandom_range(0, 2) != 0)
        r.write_count = r.read_count + CNT_W'($urandom_range(0, 96));
    end else if (pick < 96) begin
      r.action = ACT_DRAIN;
      case ($urandom_range(0, 5))
        0, 1: r.request_length = REQ_W'($urandom_range(0, 256));
        2: r.request_length = REQ_W'($urandom_range(0, 8192));
        3: r.request_length = REQ_W'(8192);
        4: ;
        default: r.request_length = REQ_W'($urandom_range(1, 4096));
      endcase
    end else if (pick < 98) begin
      r.action = ACT_RESET;
    end else begin
      r.action = ACT_SPARE;
    end
    return r;
  endfunction

  // Present one request, idling between bursts, and hold it until taken
  task automatic send_item(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= r.action;
    req_ch.write_count <= r.write_count;
    req_ch.read_count <= r.read_count;
    req_ch.request_length <= r.request_length;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
  endtask

  // Drop valid and hold until every expected result has come
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_FILL;
    req_ch.write_count = '0;
    req_ch.read_count = '0;
    req_ch.request_length = '0;
    res_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty ring, source and destination clipping, overflow, wrap
    send_item(make_request(ACT_FILL, 0, 0, 0));
    send_item(make_request(ACT_DRAIN, 0, 0, 0));
    send_item(make_request(ACT_SPARE, 1023, 1023, 16383));
    send_item(make_request(ACT_FILL, 1023, 0, 0));
    send_item(make_request(ACT_FILL, 0, 1023, 0));
    send_item(make_request(ACT_FILL, 1023, 0, 0));
    send_item(make_request(ACT_FILL, 1, 0, 0));
    send_item(make_request(ACT_DRAIN, 0, 0, 0));
    send_item(make_request(ACT_DRAIN, 0, 0, 100));
    send_item(make_request(ACT_FILL, 1, 0, 0));
    send_item(make_request(ACT_FILL, 1023, 1000, 0));
    send_item(make_request(ACT_FILL, 10, 0, 0));
    send_item(make_request(ACT_DRAIN, 0, 0, 16383));
    send_item(make_request(ACT_DRAIN, 0, 0, 8192));
    send_item(make_request(ACT_DRAIN, 1023, 1023, 8192));
    send_item(make_request(ACT_FILL, 5, 5, 0));
    send_item(make_request(ACT_FILL, 512, 513, 0));
    send_item(make_request(ACT_FILL, 1023, 1023, 0));
    send_item(make_request(ACT_RESET, 0, 0, 0));
    send_item(make_request(ACT_DRAIN, 0, 0, 1));
    send_item(make_request(ACT_FILL, 0, 1, 0));
    send_item(make_request(ACT_DRAIN, 0, 0, 16383));
    send_item(make_request(ACT_RESET, 1023, 1023, 16383));

    // Random: change the mix every 60 requests, pause once halfway
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) bias = $urandom_range(0, 2);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      send_item(random_request(bias));
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
